/* rtl/positional_list_engine_top_defines.svh */
// Assertion macros for the positional list engine.
// Both sample on aclk and are off while aresetn is low.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define PLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ple: same-cycle check failed");

// next-cycle implication
`define PLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ple: next-cycle check failed");

`endif

/* rtl/ple_pkg.sv */
`default_nettype none

package ple_pkg;

    localparam int CMD_W         = 3;
    localparam int POS_W         = 5;
    localparam int VALUE_W       = 32;
    localparam int LEN_W         = 5;
    localparam int MAXC_W        = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [MAXC_W-1:0] MAX_COUNT_RESET = 5'd16;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_COUNT = 1'b0;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    // per-word operation broadcast to every cell, already qualified
    typedef struct packed {
        logic ins;
        logic rem;
        logic wr;
        logic rd;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/positional_list_engine_top.sv */
`default_nettype none

// Channel  | Dir | Handshake          | Word contents (low bit first)
// ---------+-----+--------------------+------------------------------------------
// s_       | in  | s_tvalid/s_tready  | command[2:0] position[7:3] value[39:8]
// m_       | out | m_tvalid/m_tready  | ok[0] data[32:1] length[37:33] full_res[38]
// APB      | in  | psel/penable       | max_count at byte address 0, bits [4:0]
//
// One word per cycle: the whole row of cells shifts, loads or holds in the
// same clock edge that takes the command, and the answer lands in a single
// output register. s_tready drops only while that register is full and
// m_tready is low. aresetn is synchronous, active low; it clears the count,
// the output valid and max_count (back to 16). Cell contents are not reset.
`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top #(
    parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // command[2:0], position[7:3], value[39:8]
    input  wire logic [ple_pkg::IN_TDATA_W-1:0]    s_tdata,

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // ok[0], data[32:1], length[37:33], full_res[38], zero[39]
    output logic      [ple_pkg::OUT_TDATA_W-1:0]   m_tdata,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ple_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [ple_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [ple_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    // count width holds DEPTH itself; AW is the common compare width
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);
    localparam logic [AW-1:0] ONE_A   = AW'(1);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // ---------------- configuration ----------------
    logic [ple_pkg::MAXC_W-1:0] max_count_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ple_pkg::REG_MAX_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_count_reg <= ple_pkg::MAX_COUNT_RESET;
        end else if (cfg_wr) begin
            max_count_reg <= pwdata[ple_pkg::MAXC_W-1:0];
        end
    end

    assign prdata = (paddr == ple_pkg::REG_MAX_COUNT)
                  ? ple_pkg::CFG_DATA_W'(max_count_reg) : '0;

    // capacity: max_count saturated to 1..DEPTH
    logic [AW-1:0] mc_a;
    logic [AW-1:0] cap;

    assign mc_a = AW'(max_count_reg);

    always_comb begin
        priority if (mc_a == '0) begin
            cap = ONE_A;
        end else if (mc_a > DEPTH_A) begin
            cap = DEPTH_A;
        end else begin
            cap = mc_a;
        end
    end

    // ---------------- input word ----------------
    logic [ple_pkg::CMD_W-1:0]   in_cmd;
    logic [ple_pkg::POS_W-1:0]   in_pos;
    logic [ple_pkg::VALUE_W-1:0] in_value;
    logic                        s_acc;

    assign in_cmd   = s_tdata[2:0];
    assign in_pos   = s_tdata[7:3];
    assign in_value = s_tdata[39:8];

    logic m_valid_reg;
    logic m_valid_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- command decode ----------------
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] count_a;
    logic [AW-1:0] pos_a;
    logic          ins_ok;
    logic          rem_ok;
    logic          rd_ok;
    logic          wr_ok;
    logic          clr_ok;

    assign count_a = AW'(count_reg);
    assign pos_a   = AW'(in_pos);

    always_comb begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        rd_ok  = 1'b0;
        wr_ok  = 1'b0;
        clr_ok = 1'b0;
        unique case (in_cmd)
            ple_pkg::CMD_INSERT: ins_ok = (count_a < cap) && (pos_a <= count_a);
            ple_pkg::CMD_REMOVE: rem_ok = (pos_a < count_a);
            ple_pkg::CMD_READ:   rd_ok  = (pos_a < count_a);
            ple_pkg::CMD_WRITE:  wr_ok  = (pos_a < count_a);
            ple_pkg::CMD_CLEAR:  clr_ok = 1'b1;
            default: ; // undefined codes are rejected
        endcase
    end

    always_comb begin
        count_next = count_reg;
        priority if (ins_ok) begin
            count_next = count_reg + ONE_C;
        end else if (rem_ok) begin
            count_next = count_reg - ONE_C;
        end else if (clr_ok) begin
            count_next = '0;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (s_acc) begin
            count_reg <= count_next;
        end
    end

    // ---------------- cell row ----------------
    ple_pkg::cell_ctl_t ctl;

    assign ctl.ins = s_acc && ins_ok;
    assign ctl.rem = s_acc && rem_ok;
    assign ctl.wr  = s_acc && wr_ok;
    assign ctl.rd  = s_acc && rd_ok;

    logic [ple_pkg::VALUE_W-1:0] cell_data [DEPTH];
    logic [ple_pkg::VALUE_W-1:0] cell_rd   [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        // cell 0 never shifts up, the last cell never sees a right neighbor
        ple_cell #(
            .INDEX (i),
            .AW    (AW)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .pos        (pos_a),
            .value      (in_value),
            .left_data  ((i == 0) ? in_value : cell_data[(i == 0) ? 0 : i - 1]),
            .right_data ((i == DEPTH - 1) ? cell_data[i]
                                          : cell_data[(i == DEPTH - 1) ? i : i + 1]),
            .data_o     (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // at most one cell drives a nonzero read word
    logic [ple_pkg::VALUE_W-1:0] rd_word;

    always_comb begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    // ---------------- result register ----------------
    logic [AW-1:0]                   count_next_a;
    logic                            full_next;
    logic                            ok_next;
    logic [ple_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic [ple_pkg::OUT_TDATA_W-1:0] m_data_next;

    assign count_next_a = AW'(count_next);
    assign full_next    = (count_next_a >= cap);
    assign ok_next      = ins_ok || rem_ok || rd_ok || wr_ok || clr_ok;

    assign m_data_next = {1'b0, full_next, count_next_a[ple_pkg::LEN_W-1:0], rd_word, ok_next};

    assign m_valid_next = s_acc ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- checks ----------------
    `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `PLE_ASSERT_NEXT(a_clear_empties, s_acc && clr_ok, count_reg == '0)
    `PLE_ASSERT_NEXT(a_insert_grows, s_acc && ins_ok, count_reg == $past(count_reg) + ONE_C)
    `PLE_ASSERT_NEXT(a_reject_zero, s_acc && !ok_next, m_tdata[32:1] == '0 && !m_tdata[0])

endmodule

`default_nettype wire

/* rtl/ple_cell.sv */
`default_nettype none

// One list slot. Compares the broadcast position with its own index and
// either holds, takes the left neighbor (insert), the right neighbor
// (remove) or the new value.
module ple_cell #(
    parameter int INDEX = 0,
    parameter int AW    = 5
) (
    input  wire logic                          aclk,
    input  wire ple_pkg::cell_ctl_t            ctl,
    input  wire logic [AW-1:0]                 pos,
    input  wire logic [ple_pkg::VALUE_W-1:0]   value,
    input  wire logic [ple_pkg::VALUE_W-1:0]   left_data,
    input  wire logic [ple_pkg::VALUE_W-1:0]   right_data,
    output logic      [ple_pkg::VALUE_W-1:0]   data_o,
    output logic      [ple_pkg::VALUE_W-1:0]   rd_data
);

    localparam logic [AW-1:0] IDX = AW'(INDEX);

    logic [ple_pkg::VALUE_W-1:0] entry_reg;
    logic [ple_pkg::VALUE_W-1:0] entry_next;
    logic                        hit;

    assign hit = (pos == IDX);

    always_comb begin
        entry_next = entry_reg;
        priority if (ctl.ins) begin
            if (hit) begin
                entry_next = value;
            end else if (IDX > pos) begin
                entry_next = left_data;
            end
        end else if (ctl.rem) begin
            if (IDX >= pos) begin
                entry_next = right_data;
            end
        end else if (ctl.wr) begin
            if (hit) begin
                entry_next = value;
            end
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign data_o  = entry_reg;
    assign rd_data = (ctl.rd && hit) ? entry_reg : '0;

endmodule

`default_nettype wire
